[src/asma_pkg.sv]
// ----------------------------------------------------------------------------
// asma_pkg: shared types and constants for the accelerometer sample averager
// Window geometry, field widths, register indexes, lane control bundle and
// the raw-to-sample scaling function used by every axis lane.
// ----------------------------------------------------------------------------
package asma_pkg;

  localparam int WINDOW_SIZE = 8;              // power of two, 2..64
  localparam int WIN_LOG2    = $clog2(WINDOW_SIZE);
  localparam int WIN_IDX_W   = WIN_LOG2;
  localparam int FILL_W      = $clog2(WINDOW_SIZE + 1);

  localparam int SAMPLE_W    = 16;
  localparam int ACC_W       = 16;             // sum of entries each shifted by log2 fits
  localparam int OFFSET_W    = 18;
  localparam int OUT_W       = 19;
  localparam int CFG_DATA_W  = 18;
  localparam int CFG_IDX_W   = 2;

  localparam logic signed [14:0] SCALE_MUL   = 15'sd10000;
  localparam int                 SCALE_SHIFT = 8;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic signed [OFFSET_W-1:0] offset_t;
  typedef logic signed [OUT_W-1:0]    out_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILL_MODE = 2'd0,
    CFG_OFFSET_X  = 2'd1,
    CFG_OFFSET_Y  = 2'd2,
    CFG_OFFSET_Z  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic                 wr_en;
    logic                 wr_all;
    logic [WIN_IDX_W-1:0] wr_idx;
    logic [WIN_IDX_W-1:0] rd_idx;
    logic                 acc_clr;
    logic                 acc_en;
  } lane_ctrl_t;

  // 10-bit raw value (high byte signed, top two bits of low byte) scaled by 10000/256, floor
  function automatic sample_t make_sample(input logic [7:0] lo, input logic [7:0] hi);
    logic signed [9:0]  raw;
    logic signed [24:0] prod;
    raw  = $signed({hi, lo[7:6]});
    prod = raw * SCALE_MUL;
    return prod[SCALE_SHIFT +: SAMPLE_W];
  endfunction

endpackage

[src/asma_lane.sv]
// ----------------------------------------------------------------------------
// asma_lane: one axis lane
// Scales the raw byte pair, keeps the ring window for the axis and walks it
// one entry per cycle into a running sum of shifted entries.
// ----------------------------------------------------------------------------
module asma_lane (
  input  logic                clk,
  input  logic [7:0]          lo,
  input  logic [7:0]          hi,
  input  asma_pkg::lane_ctrl_t ctrl,
  output asma_pkg::acc_t      sum
);
  import asma_pkg::*;

  sample_t win [WINDOW_SIZE];
  sample_t sample;
  acc_t    acc;

  assign sample = make_sample(lo, hi);
  assign sum    = acc;

  // window contents are only read once every entry has been written since the last clear
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      if (ctrl.wr_all) begin
        for (int i = 0; i < WINDOW_SIZE; i++) begin
          win[i] <= sample;
        end
      end else begin
        win[ctrl.wr_idx] <= sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.acc_clr) begin
      acc <= '0;
    end else if (ctrl.acc_en) begin
      acc <= acc + ACC_W'(win[ctrl.rd_idx] >>> WIN_LOG2);
    end
  end

endmodule

[src/asma_merge.sv]
// ----------------------------------------------------------------------------
// asma_merge: result stage
// Combines the three lane sums with offsets and dither into the output
// register and holds the result request until it is taken.
// ----------------------------------------------------------------------------
module asma_merge (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  asma_pkg::acc_t    sum_x,
  input  asma_pkg::acc_t    sum_y,
  input  asma_pkg::acc_t    sum_z,
  input  logic              dither,
  input  asma_pkg::offset_t off_x,
  input  asma_pkg::offset_t off_y,
  input  asma_pkg::offset_t off_z,
  output logic              free,
  input  logic              out_ready,
  output logic              out_valid,
  output asma_pkg::out_t    accel_x,
  output asma_pkg::out_t    accel_y,
  output asma_pkg::out_t    accel_z
);
  import asma_pkg::*;

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load && free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      accel_x <= OUT_W'(sum_x) - OUT_W'(off_x);
      accel_y <= OUT_W'(sum_y) - OUT_W'(off_y);
      // Z axis is mounted inverted: dither goes in before negation
      accel_z <= out_t'('0) - (OUT_W'(sum_z) + OUT_W'(dither)) - OUT_W'(off_z);
    end
  end

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load && free |=> out_valid)
    else $error("merged result not presented");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(accel_x) && $stable(accel_z))
    else $error("pending result changed");

  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    !free |=> out_valid && $stable(accel_y))
    else $error("result stage overwritten while full");

endmodule

[src/accel_sample_moving_average.sv]
// ----------------------------------------------------------------------------
// accel_sample_moving_average: accelerometer moving-average filter
// Three axis lanes share one controller; each read that did not fail is scaled,
// written to the ring windows and, once the windows are full, summed and offset.
//
//   channel  dir  handshake            contents
//   in       in   in_valid/in_ready    read_failed, six raw bytes, dither_bit
//   out      out  out_valid/out_ready  accel_x, accel_y, accel_z
//   cfg      in   cfg_we               cfg_index, cfg_data (no read-back)
//
// A request that gives a result reaches out_valid in steps: the windows are
// written at the accepting edge, ST_SUM walks each lane's window through its
// adder entry by entry, then ST_MERGE loads the merge register once it is free.
// in_ready returns with out_valid, so no new request is taken until then.
// A failed read or a request with the window not yet full keeps in_ready high.
// A stalled out side holds the merge stage and then in_ready.
// Reset clears the fill count, write position, config registers and handshakes.
// ----------------------------------------------------------------------------
module accel_sample_moving_average (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [asma_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [asma_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           read_failed,
  input  logic [7:0]                     byte0_y_low,
  input  logic [7:0]                     byte1_y_high,
  input  logic [7:0]                     byte2_x_low,
  input  logic [7:0]                     byte3_x_high,
  input  logic [7:0]                     byte4_z_low,
  input  logic [7:0]                     byte5_z_high,
  input  logic                           dither_bit,
  output logic                           out_valid,
  input  logic                           out_ready,
  output asma_pkg::out_t                 accel_x,
  output asma_pkg::out_t                 accel_y,
  output asma_pkg::out_t                 accel_z
);
  import asma_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SUM   = 3'b010,
    ST_MERGE = 3'b100
  } state_t;

  state_t                state, state_next;
  logic                  fill_mode;
  offset_t               offset_x, offset_y, offset_z;
  logic [WIN_IDX_W-1:0]  write_position, write_position_next;
  logic [FILL_W-1:0]     fill_count, fill_count_next;
  logic [WIN_IDX_W-1:0]  sum_cnt;
  logic                  dither;
  logic                  accept;
  logic                  merge_free;
  lane_ctrl_t            ctrl;
  acc_t                  sum_x, sum_y, sum_z;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_mode <= 1'b0;
      offset_x  <= '0;
      offset_y  <= '0;
      offset_z  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FILL_MODE: fill_mode <= cfg_data[0];
        CFG_OFFSET_X:  offset_x  <= offset_t'(cfg_data);
        CFG_OFFSET_Y:  offset_y  <= offset_t'(cfg_data);
        CFG_OFFSET_Z:  offset_z  <= offset_t'(cfg_data);
        default: ;
      endcase
    end
  end

  // window bookkeeping for one request
  always_comb begin
    write_position_next = write_position;
    fill_count_next     = fill_count;
    if (read_failed) begin
      write_position_next = '0;
      fill_count_next     = '0;
    end else if (fill_mode) begin
      write_position_next = '0;
      fill_count_next     = FILL_W'(WINDOW_SIZE);
    end else begin
      write_position_next = (write_position == WIN_IDX_W'(WINDOW_SIZE - 1)) ?
                            '0 : write_position + 1'b1;
      if (fill_count < FILL_W'(WINDOW_SIZE)) begin
        fill_count_next = fill_count + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && !read_failed && fill_count_next == FILL_W'(WINDOW_SIZE)) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        if (sum_cnt == WIN_IDX_W'(WINDOW_SIZE - 1)) begin
          state_next = ST_MERGE;
        end
      end
      ST_MERGE: begin
        if (merge_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      write_position <= '0;
      fill_count     <= '0;
      sum_cnt        <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        write_position <= write_position_next;
        fill_count     <= fill_count_next;
        sum_cnt        <= '0;
      end else if (state == ST_SUM) begin
        sum_cnt <= sum_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dither <= dither_bit;
    end
  end

  always_comb begin
    ctrl.wr_en   = accept && !read_failed;
    ctrl.wr_all  = fill_mode;
    ctrl.wr_idx  = write_position;
    ctrl.rd_idx  = sum_cnt;
    ctrl.acc_clr = accept;
    ctrl.acc_en  = (state == ST_SUM);
  end

  asma_lane u_lane_x (
    .clk  (clk),
    .lo   (byte2_x_low),
    .hi   (byte3_x_high),
    .ctrl (ctrl),
    .sum  (sum_x)
  );

  asma_lane u_lane_y (
    .clk  (clk),
    .lo   (byte0_y_low),
    .hi   (byte1_y_high),
    .ctrl (ctrl),
    .sum  (sum_y)
  );

  asma_lane u_lane_z (
    .clk  (clk),
    .lo   (byte4_z_low),
    .hi   (byte5_z_high),
    .ctrl (ctrl),
    .sum  (sum_z)
  );

  asma_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .load      (state == ST_MERGE),
    .sum_x     (sum_x),
    .sum_y     (sum_y),
    .sum_z     (sum_z),
    .dither    (dither),
    .off_x     (offset_x),
    .off_y     (offset_y),
    .off_z     (offset_z),
    .free      (merge_free),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .accel_x   (accel_x),
    .accel_y   (accel_y),
    .accel_z   (accel_z)
  );

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FILL_W'(WINDOW_SIZE))
    else $error("fill count past window size");

  a_fail_clears: assert property (@(posedge clk) disable iff (rst)
    accept && read_failed |=> fill_count == '0 && write_position == '0 && state == ST_IDLE)
    else $error("failed read did not clear history");

  a_fill_mode_sums: assert property (@(posedge clk) disable iff (rst)
    accept && !read_failed && fill_mode |=> state == ST_SUM && write_position == '0)
    else $error("fill mode request did not start a sum");

  a_walk_ends: assert property (@(posedge clk) disable iff (rst)
    state == ST_SUM && sum_cnt == WIN_IDX_W'(WINDOW_SIZE - 1) |=> state == ST_MERGE)
    else $error("window walk overran");

endmodule

[tb/accel_sample_moving_average_test.sv]
// ----------------------------------------------------------------------------
// accel_sample_moving_average_test: self-checking bench for the sample averager
// Drives raw accelerometer reads through the valid/ready request channel and
// keeps a cycle-free model of the ring windows to predict each averaged
// result. Covers byte extremes, window fill and wrap, failed reads, fill mode,
// offset extremes, output back-pressure, and random streams under
// several register settings, most with random idling on both sides.
// ----------------------------------------------------------------------------
module accel_sample_moving_average_test;
  import asma_pkg::*;

  localparam int SCALE_NUM      = 10000;
  localparam int SCALE_BITS     = 8;
  localparam int IDLE_PCT       = 24;
  localparam int SETTLE_CYCLES  = 16;    // quiet time after the last result, before a register write
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic       read_failed;
    logic [7:0] y_low;
    logic [7:0] y_high;
    logic [7:0] x_low;
    logic [7:0] x_high;
    logic [7:0] z_low;
    logic [7:0] z_high;
    logic       dither;
  } read_req_t;

  typedef struct packed {
    out_t x;
    out_t y;
    out_t z;
  } accel_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic       in_valid     = 1'b0;
  logic       in_ready;
  logic       read_failed  = 1'b0;
  logic [7:0] byte0_y_low  = '0;
  logic [7:0] byte1_y_high = '0;
  logic [7:0] byte2_x_low  = '0;
  logic [7:0] byte3_x_high = '0;
  logic [7:0] byte4_z_low  = '0;
  logic [7:0] byte5_z_high = '0;
  logic       dither_bit   = 1'b0;

  logic out_valid;
  logic out_ready = 1'b0;
  out_t accel_x;
  out_t accel_y;
  out_t accel_z;

  // model state
  bit      model_fill;
  offset_t model_off_x;
  offset_t model_off_y;
  offset_t model_off_z;
  sample_t win_x [WINDOW_SIZE];
  sample_t win_y [WINDOW_SIZE];
  sample_t win_z [WINDOW_SIZE];
  logic [WIN_IDX_W-1:0] wr_pos;
  int      fill_cnt;

  accel_result_t pending_accel[$];
  int  mismatches = 0;
  bit  no_idle = 1'b0;
  int  rx_hold_cycles = 0;
  int  rx_hold_left = 0;
  int  stall_cycles = 0;

  accel_sample_moving_average u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .read_failed  (read_failed),
    .byte0_y_low  (byte0_y_low),
    .byte1_y_high (byte1_y_high),
    .byte2_x_low  (byte2_x_low),
    .byte3_x_high (byte3_x_high),
    .byte4_z_low  (byte4_z_low),
    .byte5_z_high (byte5_z_high),
    .dither_bit   (dither_bit),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .accel_x      (accel_x),
    .accel_y      (accel_y),
    .accel_z      (accel_z)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // model
  // --------------------------------------------------------------------------
  function automatic sample_t scaled_sample(input logic [7:0] lo, input logic [7:0] hi);
    int raw;
    raw = $signed({hi, lo[7:6]});
    return sample_t'((raw * SCALE_NUM) >>> SCALE_BITS);
  endfunction

  task automatic clear_history();
    for (int i = 0; i < WINDOW_SIZE; i++) begin
      win_x[i] = '0;
      win_y[i] = '0;
      win_z[i] = '0;
    end
    wr_pos   = '0;
    fill_cnt = 0;
  endtask

  task automatic predict_average(input read_req_t r);
    sample_t       sx, sy, sz;
    int            ax, ay, az;
    accel_result_t res;
    if (r.read_failed) begin
      clear_history();
      return;
    end
    sy = scaled_sample(r.y_low, r.y_high);
    sx = scaled_sample(r.x_low, r.x_high);
    sz = scaled_sample(r.z_low, r.z_high);
    if (model_fill) begin
      for (int i = 0; i < WINDOW_SIZE; i++) begin
        win_x[i] = sx;
        win_y[i] = sy;
        win_z[i] = sz;
      end
      wr_pos   = '0;
      fill_cnt = WINDOW_SIZE;
    end else begin
      win_x[wr_pos] = sx;
      win_y[wr_pos] = sy;
      win_z[wr_pos] = sz;
      wr_pos = wr_pos + 1'b1;
      if (fill_cnt < WINDOW_SIZE) fill_cnt++;
    end
    if (fill_cnt < WINDOW_SIZE) return;
    ax = 0;
    ay = 0;
    az = 0;
    for (int i = 0; i < WINDOW_SIZE; i++) begin
      ax += int'(win_x[i]) >>> WIN_LOG2;
      ay += int'(win_y[i]) >>> WIN_LOG2;
      az += int'(win_z[i]) >>> WIN_LOG2;
    end
    az += int'(r.dither);
    res.x = out_t'(ax - int'(model_off_x));
    res.y = out_t'(ay - int'(model_off_y));
    res.z = out_t'((0 - az) - int'(model_off_z));
    pending_accel.push_back(res);
  endtask

  // --------------------------------------------------------------------------
  // request side
  // --------------------------------------------------------------------------
  task automatic send_read(input read_req_t r);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    read_failed  <= r.read_failed;
    byte0_y_low  <= r.y_low;
    byte1_y_high <= r.y_high;
    byte2_x_low  <= r.x_low;
    byte3_x_high <= r.x_high;
    byte4_z_low  <= r.z_low;
    byte5_z_high <= r.z_high;
    dither_bit   <= r.dither;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_average(r);
  endtask

  // drop valid, let every expected result out, then let the block settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_accel.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      CFG_FILL_MODE: model_fill  = data[0];
      CFG_OFFSET_X:  model_off_x = offset_t'(data);
      CFG_OFFSET_Y:  model_off_y = offset_t'(data);
      CFG_OFFSET_Z:  model_off_z = offset_t'(data);
      default: ;
    endcase
  endtask

  task automatic configure(input bit fill, input offset_t ox, input offset_t oy,
                           input offset_t oz);
    drain_results();
    write_reg(CFG_FILL_MODE, {{(CFG_DATA_W-1){1'b0}}, fill});
    write_reg(CFG_OFFSET_X, ox);
    write_reg(CFG_OFFSET_Y, oy);
    write_reg(CFG_OFFSET_Z, oz);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] raw_byte();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h7F;
      3: return 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic read_req_t random_read(input int fail_pct);
    read_req_t r;
    r.read_failed = ($urandom_range(99) < fail_pct);
    r.y_low  = raw_byte();
    r.y_high = raw_byte();
    r.x_low  = raw_byte();
    r.x_high = raw_byte();
    r.z_low  = raw_byte();
    r.z_high = raw_byte();
    r.dither = 1'($urandom_range(1));
    return r;
  endfunction

  function automatic read_req_t make_read(input logic fail, input logic [7:0] ylo,
                                          input logic [7:0] yhi, input logic [7:0] xlo,
                                          input logic [7:0] xhi, input logic [7:0] zlo,
                                          input logic [7:0] zhi, input logic dith);
    read_req_t r;
    r = '{fail, ylo, yhi, xlo, xhi, zlo, zhi, dith};
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // result side: check, then pick next ready
  // --------------------------------------------------------------------------
  task automatic check_axis(input string axis, input out_t want, input out_t got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, axis, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    accel_result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_accel.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual x=%0d y=%0d z=%0d",
                   $time, accel_x, accel_y, accel_z);
          mismatches++;
        end else begin
          want = pending_accel.pop_front();
          check_axis("accel_x", want.x, accel_x);
          check_axis("accel_y", want.y, accel_y);
          check_axis("accel_z", want.z, accel_z);
        end
      end
      if (rx_hold_left == 0 && rx_hold_cycles > 0) begin
        rx_hold_left   = rx_hold_cycles;
        rx_hold_cycles = 0;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("accel_sample_moving_average regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_window_fill();
    logic [7:0] ext_hi [4];
    logic [7:0] ext_lo [4];
    ext_hi = '{8'h7F, 8'h80, 8'h00, 8'hFF};
    ext_lo = '{8'hC0, 8'h00, 8'h40, 8'hFF};
    configure(1'b0, '0, '0, '0);
    // seven silent requests, then results from the eighth on, across the wrap
    for (int i = 0; i < 10; i++)
      send_read(make_read(1'b0, ext_lo[i % 4], ext_hi[i % 4], ext_lo[(i + 1) % 4],
                          ext_hi[(i + 1) % 4], ext_lo[(i + 2) % 4], ext_hi[(i + 2) % 4],
                          1'(i)));
  endtask

  task automatic test_failed_read();
    send_read(make_read(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
    for (int i = 0; i < 3; i++)
      send_read(make_read(1'b0, 8'hC0, 8'h7F, 8'hC0, 8'h7F, 8'h00, 8'h80, 1'b1));
    send_read(make_read(1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
  endtask

  task automatic test_fill_mode();
    configure(1'b1, -18'sd131072, -18'sd131072, 18'sd131071);
    send_read(make_read(1'b0, 8'hC0, 8'h7F, 8'hC0, 8'h7F, 8'hC0, 8'h7F, 1'b0));
    send_read(make_read(1'b0, 8'h00, 8'h80, 8'h00, 8'h80, 8'h00, 8'h80, 1'b1));
    send_read(make_read(1'b1, 8'h3F, 8'h12, 8'h3F, 8'h34, 8'h3F, 8'h56, 1'b1));
    send_read(make_read(1'b0, 8'hC0, 8'h7F, 8'hC0, 8'h7F, 8'hC0, 8'h7F, 1'b1));
    configure(1'b1, 18'sd131071, 18'sd131071, -18'sd131072);
    send_read(make_read(1'b0, 8'h00, 8'h80, 8'h00, 8'h80, 8'h00, 8'h80, 1'b1));
    send_read(make_read(1'b0, 8'hC0, 8'h7F, 8'h40, 8'hFF, 8'h80, 8'h00, 1'b0));
  endtask

  task automatic test_output_stall();
    configure(1'b1, offset_t'($urandom), offset_t'($urandom), offset_t'($urandom));
    no_idle = 1'b1;
    rx_hold_cycles = HOLD_CYCLES;
    for (int i = 0; i < 40; i++) send_read(random_read(0));
    no_idle = 1'b0;
  endtask

  task automatic test_sender_pause();
    configure(1'b0, offset_t'($urandom), offset_t'($urandom), offset_t'($urandom));
    for (int i = 0; i < 20; i++) send_read(random_read(2));
    drain_results();
    for (int i = 0; i < 20; i++) send_read(random_read(2));
  endtask

  task automatic test_random_stream(input bit fill, input offset_t ox, input offset_t oy,
                                    input offset_t oz, input int count, input int fail_pct,
                                    input bit steady);
    configure(fill, ox, oy, oz);
    no_idle = steady;
    for (int i = 0; i < count; i++) send_read(random_read(fail_pct));
    no_idle = 1'b0;
  endtask

  initial begin
    model_fill  = 1'b0;
    model_off_x = '0;
    model_off_y = '0;
    model_off_z = '0;
    clear_history();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_window_fill();
    test_failed_read();
    test_fill_mode();
    test_output_stall();
    test_sender_pause();
    test_random_stream(1'b0, '0, '0, '0, 170, 3, 1'b0);
    test_random_stream(1'b0, -18'sd131072, 18'sd131071, -18'sd131072, 150, 3, 1'b1);
    test_random_stream(1'b1, 18'sd131071, -18'sd131072, 18'sd131071, 150, 5, 1'b0);
    test_random_stream(1'b0, offset_t'($urandom), offset_t'($urandom), offset_t'($urandom),
                       170, 2, 1'b0);
    test_random_stream(1'b1, offset_t'($urandom), offset_t'($urandom), offset_t'($urandom),
                       150, 10, 1'b0);
    test_random_stream(1'b0, offset_t'($urandom), offset_t'($urandom), offset_t'($urandom),
                       150, 15, 1'b0);

    drain_results();
    if (mismatches == 0) begin
      $display("accel_sample_moving_average regression: pass");
    end else begin
      $display("accel_sample_moving_average regression: fail");
    end
    $finish;
  end

endmodule

[sim.f]
src/asma_pkg.sv
src/asma_lane.sv
src/asma_merge.sv
src/accel_sample_moving_average.sv
tb/accel_sample_moving_average_test.sv
